/* hdl/tcp_packet_fault_dropper_unit_assert.svh */
// assertion macros shared by the dropper modules
`ifndef TCP_PACKET_FAULT_DROPPER_UNIT_ASSERT_SVH
`define TCP_PACKET_FAULT_DROPPER_UNIT_ASSERT_SVH

// check that is switched off while reset is high
`define TPFD_CHECK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// check that holds through reset as well
`define TPFD_CHECK_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

/* hdl/tpfd_pkg.sv */
// types, codes and constants of the tcp fault dropper
`timescale 1ns / 1ps
package tpfd_pkg;

  localparam int TPFD_COUNTER_BITS = 32;

  // frame classes
  localparam logic [2:0] CLS_NONE   = 3'd0;
  localparam logic [2:0] CLS_SYN    = 3'd1;
  localparam logic [2:0] CLS_SYNACK = 3'd2;
  localparam logic [2:0] CLS_FIN    = 3'd3;
  localparam logic [2:0] CLS_ACK    = 3'd4;
  localparam logic [2:0] CLS_DATA   = 3'd5;

  // class counter slots
  localparam int NUM_COUNTERS = 4;
  localparam logic [1:0] CNT_SYN    = 2'd0;
  localparam logic [1:0] CNT_SYNACK = 2'd1;
  localparam logic [1:0] CNT_FIN    = 2'd2;
  localparam logic [1:0] CNT_DATA   = 2'd3;

  // configuration register indexes
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_SYN_FIRST    = 3'd0;
  localparam logic [2:0] REG_SYNACK_FIRST = 3'd1;
  localparam logic [2:0] REG_FIN_FIRST    = 3'd2;
  localparam logic [2:0] REG_ACK_PERCENT  = 3'd3;
  localparam logic [2:0] REG_DATA_INDEX   = 3'd4;
  localparam logic [2:0] REG_DATA_PERCENT = 3'd5;

  // header layout
  localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
  localparam logic [15:0] POS_IP_VER_IHL = 16'd14;
  localparam logic [15:0] POS_IP_LEN_HI  = 16'd16;
  localparam logic [15:0] POS_IP_LEN_LO  = 16'd17;
  localparam logic [15:0] POS_IP_PROTO   = 16'd23;
  localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
  localparam logic [15:0] TCP_DOFF_OFS   = 16'd12;
  localparam logic [15:0] TCP_FLAGS_OFS  = 16'd13;
  localparam logic [6:0]  ETH_TCP_MIN    = 7'd34;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd54;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
  localparam logic [15:0] LEN_MAX        = 16'hFFFF;

  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_ACK = 4;

  // queue between front and back, depth a power of two
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  typedef struct packed {
    logic [15:0] syn_first;
    logic [15:0] synack_first;
    logic [15:0] fin_first;
    logic [6:0]  ack_percent;
    logic [15:0] data_index;
    logic [6:0]  data_percent;
  } tpfd_cfg_t;

  // classified frame waiting for its verdict
  typedef struct packed {
    logic [2:0]  cls;
    logic [6:0]  rnd;
    logic [15:0] len;
  } tpfd_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } tpfd_qstat_t;

endpackage

/* hdl/tpfd_frame_if.sv */
// byte channel carrying the outgoing frame
`timescale 1ns / 1ps
interface tpfd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic [6:0] random_percent;

  modport source (output valid, output frame_byte, output frame_end,
                  output random_percent, input ready);
  modport sink (input valid, input frame_byte, input frame_end,
                input random_percent, output ready);
endinterface

/* hdl/tpfd_verdict_if.sv */
// result channel carrying class, drop decision and length
`timescale 1ns / 1ps
interface tpfd_verdict_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_class;
  logic        drop_frame;
  logic [15:0] frame_length;

  modport source (output valid, output frame_class, output drop_frame,
                  output frame_length, input ready);
  modport sink (input valid, input frame_class, input drop_frame,
                input frame_length, output ready);
endinterface

/* hdl/tcp_packet_fault_dropper_unit.sv */
// top level of the tcp fault dropper
`timescale 1ns / 1ps
// Takes outgoing ethernet frames one byte per word on the frame channel and
// returns one word on the verdict channel per frame (class, drop decision,
// saturated byte count), issued for the byte marked frame_end. Throughput is
// one byte per cycle with no gap between frames while the queue is not full.
// The front captures header fields as bytes stream by and classifies the
// frame on its last byte; the result goes into a four-entry queue, and the
// back pops it once the verdict register is empty or being taken, bumps the
// saturating class counter and registers the verdict. The frame channel only
// stalls when four verdicts are queued while the output is held by the sink.
// Six configuration registers sit on the apb port at byte addresses 0x00 to
// 0x14; they are meant to be written while no frame is in flight. Class
// counters clear on reset only.
module tcp_packet_fault_dropper_unit
  import tpfd_pkg::*;
#(
  parameter int COUNTER_BITS = TPFD_COUNTER_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  tpfd_frame_if.sink            frame,
  tpfd_verdict_if.source        verdict,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  tpfd_cfg_t   cfg;
  tpfd_qstat_t qstat;
  tpfd_item_t  push_item;
  tpfd_item_t  pop_item;
  logic        push;
  logic        pop;
  logic        cfg_write;
  logic [2:0]  reg_idx;

  // register file, one 32-bit slot per register
  assign pready    = 1'b1;
  assign reg_idx   = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_SYN_FIRST:    cfg.syn_first    <= pwdata[15:0];
        REG_SYNACK_FIRST: cfg.synack_first <= pwdata[15:0];
        REG_FIN_FIRST:    cfg.fin_first    <= pwdata[15:0];
        REG_ACK_PERCENT:  cfg.ack_percent  <= pwdata[6:0];
        REG_DATA_INDEX:   cfg.data_index   <= pwdata[15:0];
        REG_DATA_PERCENT: cfg.data_percent <= pwdata[6:0];
        default: begin
          // writes past the register list are ignored
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SYN_FIRST:    prdata = {16'd0, cfg.syn_first};
      REG_SYNACK_FIRST: prdata = {16'd0, cfg.synack_first};
      REG_FIN_FIRST:    prdata = {16'd0, cfg.fin_first};
      REG_ACK_PERCENT:  prdata = {25'd0, cfg.ack_percent};
      REG_DATA_INDEX:   prdata = {16'd0, cfg.data_index};
      REG_DATA_PERCENT: prdata = {25'd0, cfg.data_percent};
      default:          prdata = '0;
    endcase
  end

  // byte capture and classification
  tpfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // classified frames waiting for a verdict
  tpfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (qstat)
  );

  // counters and drop decision
  tpfd_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .qstat   (qstat),
    .item    (pop_item),
    .pop     (pop),
    .verdict (verdict)
  );

endmodule

/* hdl/tpfd_queue.sv */
// short queue of classified frames between front and back
`timescale 1ns / 1ps
module tpfd_queue
  import tpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  tpfd_item_t  push_item,
  input  logic        pop,
  output tpfd_item_t  pop_item,
  output tpfd_qstat_t stat
);

  tpfd_item_t             slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;

  assign stat.full  = (fill == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign stat.valid = (fill != '0);
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`include "tcp_packet_fault_dropper_unit_assert.svh"

  `TPFD_CHECK(a_no_overflow, clk, rst, push |-> !stat.full || pop, "push into full queue")
  `TPFD_CHECK(a_no_underflow, clk, rst, pop |-> stat.valid, "pop from empty queue")
  `TPFD_CHECK(a_fill_bound, clk, rst, fill <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue fill past depth")

endmodule

/* hdl/tpfd_front.sv */
// byte capture and end-of-frame classification
`timescale 1ns / 1ps
module tpfd_front
  import tpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tpfd_frame_if.sink  frame,
  input  tpfd_qstat_t qstat,
  output logic        push,
  output tpfd_item_t  push_item
);

  logic [15:0] byte_position;
  logic [15:0] ether_type_seen;
  logic [3:0]  ip_header_words;
  logic [7:0]  ip_protocol_seen;
  logic [15:0] ip_total_length;
  logic [3:0]  tcp_header_words;
  logic [7:0]  tcp_flag_bits;

  logic [15:0] etype_next;
  logic [3:0]  ihl_next;
  logic [7:0]  proto_next;
  logic [15:0] total_next;
  logic [3:0]  doff_next;
  logic [15:0] flags_pos;
  logic [15:0] doff_pos;
  logic [7:0]  flags_next;
  logic [15:0] len_next;
  logic [6:0]  tcp_base;
  logic [6:0]  hdr_len;
  logic [6:0]  min_len;
  logic        hdr_ok;
  logic        has_payload;
  logic [2:0]  cls;
  logic        accept;

  assign frame.ready = !qstat.full;
  assign accept      = frame.valid && frame.ready;

  // fields including the byte in flight
  always_comb begin
    etype_next = ether_type_seen;
    ihl_next   = ip_header_words;
    proto_next = ip_protocol_seen;
    total_next = ip_total_length;
    doff_next  = tcp_header_words;
    flags_next = tcp_flag_bits;
    tcp_base   = ETH_HDR_LEN + {1'b0, ip_header_words, 2'b00};
    doff_pos   = {9'd0, tcp_base} + TCP_DOFF_OFS;
    flags_pos  = {9'd0, tcp_base} + TCP_FLAGS_OFS;
    if (byte_position == POS_ETYPE_HI) etype_next[15:8] = frame.frame_byte;
    if (byte_position == POS_ETYPE_LO) etype_next[7:0] = frame.frame_byte;
    if (byte_position == POS_IP_VER_IHL) ihl_next = frame.frame_byte[3:0];
    if (byte_position == POS_IP_LEN_HI) total_next[15:8] = frame.frame_byte;
    if (byte_position == POS_IP_LEN_LO) total_next[7:0] = frame.frame_byte;
    if (byte_position == POS_IP_PROTO) proto_next = frame.frame_byte;
    // tcp header may overlap the ip header when ihl is small
    if (byte_position > POS_IP_VER_IHL && byte_position == doff_pos) begin
      doff_next = frame.frame_byte[7:4];
    end
    if (byte_position > POS_IP_VER_IHL && byte_position == flags_pos) begin
      flags_next = frame.frame_byte;
    end
    len_next = (byte_position == LEN_MAX) ? byte_position : byte_position + 16'd1;
  end

  // classification on the last byte
  always_comb begin
    hdr_len     = {1'b0, ihl_next, 2'b00} + {1'b0, doff_next, 2'b00};
    min_len     = ETH_TCP_MIN + {1'b0, ihl_next, 2'b00};
    hdr_ok      = (len_next >= MIN_FRAME_LEN) && (etype_next == ETHERTYPE_IPV4) &&
                  (proto_next == IP_PROTO_TCP) && (len_next >= {9'd0, min_len}) &&
                  (total_next >= {9'd0, hdr_len});
    has_payload = (total_next != {9'd0, hdr_len});
    priority if (!hdr_ok) begin
      cls = CLS_NONE;
    end else if (flags_next[FLAG_SYN] && flags_next[FLAG_ACK]) begin
      cls = CLS_SYNACK;
    end else if (flags_next[FLAG_SYN]) begin
      cls = CLS_SYN;
    end else if (flags_next[FLAG_FIN]) begin
      cls = CLS_FIN;
    end else if (has_payload) begin
      cls = CLS_DATA;
    end else if (flags_next[FLAG_ACK]) begin
      cls = CLS_ACK;
    end else begin
      cls = CLS_NONE;
    end
  end

  assign push          = accept && frame.frame_end;
  assign push_item.cls = cls;
  assign push_item.rnd = frame.random_percent;
  assign push_item.len = len_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_position    <= '0;
      ether_type_seen  <= '0;
      ip_header_words  <= '0;
      ip_protocol_seen <= '0;
      ip_total_length  <= '0;
      tcp_header_words <= '0;
      tcp_flag_bits    <= '0;
    end else if (accept) begin
      byte_position    <= len_next;
      ether_type_seen  <= etype_next;
      ip_header_words  <= ihl_next;
      ip_protocol_seen <= proto_next;
      ip_total_length  <= total_next;
      tcp_header_words <= doff_next;
      tcp_flag_bits    <= flags_next;
    end
  end

endmodule

/* hdl/tpfd_back.sv */
// class counters, drop decision and result register
`timescale 1ns / 1ps
module tpfd_back
  import tpfd_pkg::*;
#(
  parameter int COUNTER_BITS = TPFD_COUNTER_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  tpfd_cfg_t     cfg,
  input  tpfd_qstat_t   qstat,
  input  tpfd_item_t    item,
  output logic          pop,
  tpfd_verdict_if.source verdict
);

  localparam logic [COUNTER_BITS-1:0] CNT_TOP = '1;

  logic [COUNTER_BITS-1:0] counters [NUM_COUNTERS];
  logic [COUNTER_BITS-1:0] cnt_bumped;
  logic [1:0]              cnt_idx;
  logic                    counted;
  logic [15:0]             first_limit;
  logic                    drop;

  assign pop = qstat.valid && (!verdict.valid || verdict.ready);

  always_comb begin
    cnt_idx     = CNT_SYN;
    counted     = 1'b0;
    first_limit = '0;
    unique case (item.cls)
      CLS_SYN: begin
        cnt_idx     = CNT_SYN;
        counted     = 1'b1;
        first_limit = cfg.syn_first;
      end
      CLS_SYNACK: begin
        cnt_idx     = CNT_SYNACK;
        counted     = 1'b1;
        first_limit = cfg.synack_first;
      end
      CLS_FIN: begin
        cnt_idx     = CNT_FIN;
        counted     = 1'b1;
        first_limit = cfg.fin_first;
      end
      CLS_DATA: begin
        cnt_idx = CNT_DATA;
        counted = 1'b1;
      end
      default: begin
        counted = 1'b0;
      end
    endcase
    cnt_bumped = (counters[cnt_idx] == CNT_TOP) ? CNT_TOP : counters[cnt_idx] + 1'b1;
  end

  always_comb begin
    unique case (item.cls)
      CLS_SYN, CLS_SYNACK, CLS_FIN: begin
        drop = (first_limit != '0) && (cnt_bumped <= COUNTER_BITS'(first_limit));
      end
      CLS_ACK: begin
        drop = item.rnd < cfg.ack_percent;
      end
      CLS_DATA: begin
        drop = ((cfg.data_index != '0) && (cnt_bumped == COUNTER_BITS'(cfg.data_index))) ||
               (item.rnd < cfg.data_percent);
      end
      default: begin
        drop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        counters[i] <= '0;
      end
    end else if (pop && counted) begin
      counters[cnt_idx] <= cnt_bumped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (pop) begin
      verdict.valid <= 1'b1;
    end else if (verdict.ready) begin
      verdict.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict.frame_class  <= item.cls;
      verdict.drop_frame   <= drop;
      verdict.frame_length <= item.len;
    end
  end

`include "tcp_packet_fault_dropper_unit_assert.svh"

  `TPFD_CHECK(a_none_kept, clk, rst, verdict.valid && verdict.frame_class == CLS_NONE |-> !verdict.drop_frame, "unclassified frame dropped")
  `TPFD_CHECK(a_data_cnt_mono, clk, rst, !$past(rst) |-> counters[CNT_DATA] >= $past(counters[CNT_DATA]), "data counter went down")
  `TPFD_CHECK(a_syn_cnt_mono, clk, rst, !$past(rst) |-> counters[CNT_SYN] >= $past(counters[CNT_SYN]), "syn counter went down")
  `TPFD_CHECK(a_pop_loads, clk, rst, pop |=> verdict.valid, "popped frame not presented")

endmodule

/* dv/tpfd_verdict_check.sv */
// checker for the tcp fault dropper: predicts each verdict word and compares
`timescale 1ns / 1ps
module tpfd_verdict_check
  import tpfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  tpfd_frame_if                 frame,
  tpfd_verdict_if               verdict,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [31:0] CNT_TOP = 32'hFFFF_FFFF >> (32 - TPFD_COUNTER_BITS);

  typedef struct {
    logic [2:0]  cls;
    logic        drop;
    logic [15:0] len;
  } verdict_word_t;

  verdict_word_t verdicts_due[$];

  // per-frame captures
  logic [15:0] pos;
  logic [15:0] etype;
  logic [3:0]  ihl;
  logic [7:0]  proto;
  logic [15:0] ip_len;
  logic [3:0]  doff;
  logic [7:0]  flags;
  logic [31:0] class_cnt [NUM_COUNTERS];
  tpfd_cfg_t   cfg;

  function automatic void clear_frame();
    pos    = '0;
    etype  = '0;
    ihl    = '0;
    proto  = '0;
    ip_len = '0;
    doff   = '0;
    flags  = '0;
  endfunction

  function automatic logic [31:0] bump_count(input logic [1:0] slot);
    if (class_cnt[slot] < CNT_TOP) class_cnt[slot] = class_cnt[slot] + 1;
    return class_cnt[slot];
  endfunction

  function automatic logic [2:0] classify_frame(input logic [15:0] len);
    int   ip_hlen;
    int   doff_bytes;
    logic syn_f;
    logic fin_f;
    logic ack_f;
    ip_hlen    = int'(ihl) * 4;
    doff_bytes = int'(doff) * 4;
    syn_f      = flags[FLAG_SYN];
    fin_f      = flags[FLAG_FIN];
    ack_f      = flags[FLAG_ACK];
    if (len < MIN_FRAME_LEN) return CLS_NONE;
    if (etype != ETHERTYPE_IPV4) return CLS_NONE;
    if (proto != IP_PROTO_TCP) return CLS_NONE;
    if (int'(len) < int'(ETH_TCP_MIN) + ip_hlen) return CLS_NONE;
    if (int'(ip_len) < ip_hlen + doff_bytes) return CLS_NONE;
    if (syn_f && ack_f) return CLS_SYNACK;
    if (syn_f) return CLS_SYN;
    if (fin_f) return CLS_FIN;
    if (int'(ip_len) - ip_hlen - doff_bytes > 0) return CLS_DATA;
    if (ack_f) return CLS_ACK;
    return CLS_NONE;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic last, input logic [6:0] rnd);
    int            tcp_base;
    logic [31:0]   n;
    verdict_word_t v;
    // tcp header follows the ip header as ihl says, even when ihl is short
    tcp_base = int'(ETH_HDR_LEN) + int'(ihl) * 4;
    if (pos == POS_ETYPE_HI) etype[15:8] = b;
    if (pos == POS_ETYPE_LO) etype[7:0] = b;
    if (pos == POS_IP_VER_IHL) ihl = b[3:0];
    if (pos == POS_IP_LEN_HI) ip_len[15:8] = b;
    if (pos == POS_IP_LEN_LO) ip_len[7:0] = b;
    if (pos == POS_IP_PROTO) proto = b;
    if (pos > POS_IP_VER_IHL && int'(pos) == tcp_base + int'(TCP_DOFF_OFS)) doff = b[7:4];
    if (pos > POS_IP_VER_IHL && int'(pos) == tcp_base + int'(TCP_FLAGS_OFS)) flags = b;
    if (pos != LEN_MAX) pos = pos + 1;
    if (last) begin
      v.len  = pos;
      v.cls  = classify_frame(pos);
      v.drop = 1'b0;
      case (v.cls)
        CLS_SYN: begin
          n = bump_count(CNT_SYN);
          v.drop = cfg.syn_first != 0 && n <= cfg.syn_first;
        end
        CLS_SYNACK: begin
          n = bump_count(CNT_SYNACK);
          v.drop = cfg.synack_first != 0 && n <= cfg.synack_first;
        end
        CLS_FIN: begin
          n = bump_count(CNT_FIN);
          v.drop = cfg.fin_first != 0 && n <= cfg.fin_first;
        end
        CLS_ACK: v.drop = rnd < cfg.ack_percent;
        CLS_DATA: begin
          n = bump_count(CNT_DATA);
          v.drop = (cfg.data_index != 0 && n == cfg.data_index) || rnd < cfg.data_percent;
        end
        default: ;
      endcase
      verdicts_due.push_back(v);
      clear_frame();
    end
  endtask

  task automatic compare_verdict();
    verdict_word_t exp_v;
    if (verdicts_due.size() == 0) begin
      $error("verdict word with none expected: class %0d drop %0d length %0d",
             verdict.frame_class, verdict.drop_frame, verdict.frame_length);
      fail_count++;
      return;
    end
    exp_v = verdicts_due.pop_front();
    if (verdict.frame_class !== exp_v.cls) begin
      $error("frame_class mismatch: expected %0d, actual %0d", exp_v.cls, verdict.frame_class);
      fail_count++;
    end
    if (verdict.drop_frame !== exp_v.drop) begin
      $error("drop_frame mismatch: expected %0d, actual %0d", exp_v.drop, verdict.drop_frame);
      fail_count++;
    end
    if (verdict.frame_length !== exp_v.len) begin
      $error("frame_length mismatch: expected %0d, actual %0d",
             exp_v.len, verdict.frame_length);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_frame();
      foreach (class_cnt[i]) class_cnt[i] = '0;
      cfg = '0;
      verdicts_due.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_SYN_FIRST:    cfg.syn_first    = pwdata[15:0];
          REG_SYNACK_FIRST: cfg.synack_first = pwdata[15:0];
          REG_FIN_FIRST:    cfg.fin_first    = pwdata[15:0];
          REG_ACK_PERCENT:  cfg.ack_percent  = pwdata[6:0];
          REG_DATA_INDEX:   cfg.data_index   = pwdata[15:0];
          REG_DATA_PERCENT: cfg.data_percent = pwdata[6:0];
          default: ;
        endcase
      end
      // compare before taking a new byte so a result can never match its own frame early
      if (verdict.valid && verdict.ready) compare_verdict();
      if (frame.valid && frame.ready)
        absorb_byte(frame.frame_byte, frame.frame_end, frame.random_percent);
      pending = verdicts_due.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// testbench top for the tcp fault dropper: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import tpfd_pkg::*;

  // cycles with no word moving on either channel before the run is abandoned
  localparam int STALL_LIMIT   = 2000;
  // idle time after the last expected verdict, as margin before the registers change
  localparam int SETTLE_CYCLES = 8;

  // tcp flag bytes built from the package bit positions
  localparam logic [7:0] F_FIN    = 8'(1 << FLAG_FIN);
  localparam logic [7:0] F_SYN    = 8'(1 << FLAG_SYN);
  localparam logic [7:0] F_ACK    = 8'(1 << FLAG_ACK);
  localparam logic [7:0] F_PSH    = 8'h08;
  localparam logic [7:0] F_SYNACK = F_SYN | F_ACK;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int src_idle_pct = 21;
  int snk_idle_pct = 80;
  int stall_cycles = 0;

  // bytes of the frame about to be sent
  logic [7:0] frame_bytes[$];

  tpfd_frame_if   frame_ch();
  tpfd_verdict_if verdict_ch();

  tcp_packet_fault_dropper_unit dut (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_ch),
    .verdict (verdict_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tpfd_verdict_check verdict_chk (
    .clk        (clk),
    .rst        (rst),
    .frame      (frame_ch),
    .verdict    (verdict_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    verdict_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // watchdog: any word moving on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (frame_ch.valid && frame_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // apb write: setup cycle, then access cycle until pready, then back to idle
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] syn_n, input logic [15:0] synack_n,
                              input logic [15:0] fin_n, input logic [6:0] ack_pct,
                              input logic [15:0] data_idx, input logic [6:0] data_pct);
    apb_write(REG_SYN_FIRST,    32'(syn_n));
    apb_write(REG_SYNACK_FIRST, 32'(synack_n));
    apb_write(REG_FIN_FIRST,    32'(fin_n));
    apb_write(REG_ACK_PERCENT,  32'(ack_pct));
    apb_write(REG_DATA_INDEX,   32'(data_idx));
    apb_write(REG_DATA_PERCENT, 32'(data_pct));
  endtask

  // drop valid, let every expected verdict come back, then wait out SETTLE_CYCLES
  // so nothing is still in flight before the registers change
  task automatic wait_idle();
    frame_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one byte word; random gaps ahead of it, held until accepted
  task automatic send_word(input logic [7:0] b, input logic last, input logic [6:0] rnd);
    while ($urandom_range(99) < src_idle_pct) begin
      frame_ch.valid <= 1'b0;
      @(negedge clk);
    end
    frame_ch.valid          <= 1'b1;
    frame_ch.frame_byte     <= b;
    frame_ch.frame_end      <= last;
    frame_ch.random_percent <= rnd;
    do @(posedge clk); while (!frame_ch.ready);
    @(negedge clk);
  endtask

  // the draw only matters on the last byte; the rest carry noise
  task automatic send_frame(input logic [6:0] last_rnd);
    int n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_word(frame_bytes[i], 1'b1, last_rnd);
      else send_word(frame_bytes[i], 1'b0, 7'($urandom_range(99)));
    end
  endtask

  function automatic void put_byte(input int at, input logic [7:0] b);
    if (at < frame_bytes.size()) frame_bytes[at] = b;
  endfunction

  function automatic void fill_frame(input int len, input logic [7:0] b);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(b);
  endfunction

  // ethernet + ipv4 + tcp frame over random content; tot_adj skews the ip total
  // length field, len_adj pads (positive) or truncates (negative) the frame
  task automatic build_tcp(input logic [3:0] ihl, input logic [3:0] doff,
                           input logic [7:0] flags, input int pay,
                           input logic [15:0] etype, input logic [7:0] proto,
                           input int tot_adj, input int len_adj);
    int hdr;
    int tot;
    int len;
    int tcp_base;
    hdr = 4 * int'(ihl) + 4 * int'(doff);
    tot = hdr + pay + tot_adj;
    if (tot < 0) tot = 0;
    if (tot > 65535) tot = 65535;
    len = int'(ETH_HDR_LEN) + hdr + pay + len_adj;
    if (len < 1) len = 1;
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom));
    tcp_base = int'(ETH_HDR_LEN) + 4 * int'(ihl);
    put_byte(int'(POS_ETYPE_HI), etype[15:8]);
    put_byte(int'(POS_ETYPE_LO), etype[7:0]);
    put_byte(int'(POS_IP_VER_IHL), {4'h4, ihl});
    put_byte(int'(POS_IP_LEN_HI), 8'(tot >> 8));
    put_byte(int'(POS_IP_LEN_LO), 8'(tot));
    put_byte(int'(POS_IP_PROTO), proto);
    put_byte(tcp_base + int'(TCP_DOFF_OFS), {doff, 4'($urandom)});
    put_byte(tcp_base + int'(TCP_FLAGS_OFS), flags);
  endtask

  // mostly well-formed tcp frames so the class counters and drop rules get
  // real traffic; the rest are broken headers and plain noise
  task automatic random_frame();
    int         kind;
    int         pay;
    int         base_len;
    int         len_adj;
    logic [3:0] ihl;
    logic [3:0] doff;
    logic [7:0] flags;
    kind = $urandom_range(99);
    ihl  = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd5;
    doff = ($urandom_range(9) == 0) ? 4'($urandom) : 4'd5;
    case ($urandom_range(5))
      0: flags = F_SYN;
      1: flags = F_SYNACK;
      2: flags = F_FIN | F_ACK;
      3: flags = F_ACK;
      4: flags = F_PSH | F_ACK;
      default: flags = 8'($urandom);
    endcase
    if (flags == (F_PSH | F_ACK)) pay = $urandom_range(1, 40);
    else pay = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : 0;
    // pad short frames up to the 60-byte ethernet minimum now and then
    base_len = int'(ETH_HDR_LEN) + 4 * int'(ihl) + 4 * int'(doff) + pay;
    len_adj  = $urandom_range(0, 6);
    if (base_len < 60 && $urandom_range(1) == 0) len_adj = len_adj + 60 - base_len;
    if (kind < 75) begin
      build_tcp(ihl, doff, flags, pay, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, len_adj);
    end else if (kind < 88) begin
      case ($urandom_range(4))
        0: build_tcp(ihl, doff, flags, pay, 16'($urandom), IP_PROTO_TCP, 0, len_adj);
        1: build_tcp(ihl, doff, flags, pay, ETHERTYPE_IPV4, 8'($urandom), 0, len_adj);
        2: build_tcp(ihl, doff, flags, pay, ETHERTYPE_IPV4, IP_PROTO_TCP, 0,
                     -$urandom_range(1, 30));
        3: build_tcp(ihl, doff, flags, pay, ETHERTYPE_IPV4, IP_PROTO_TCP,
                     -$urandom_range(1, 40), len_adj);
        default: build_tcp(ihl, doff, flags, pay, ETHERTYPE_IPV4, IP_PROTO_TCP,
                           $urandom_range(1, 300), len_adj);
      endcase
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 90)) frame_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic random_traffic(input int min_bytes, input int min_frames);
    int bytes_sent;
    int frames_sent;
    bytes_sent  = 0;
    frames_sent = 0;
    while (bytes_sent < min_bytes || frames_sent < min_frames) begin
      random_frame();
      bytes_sent += frame_bytes.size();
      frames_sent++;
      send_frame(7'($urandom_range(99)));
    end
  endtask

  // hand-picked frames: header extremes, every class and the corner rules
  task automatic directed_frames();
    // single-byte frame, all ones
    fill_frame(1, 8'hFF);
    send_frame(7'd0);
    // all-zero and all-ones minimum ethernet frames, both unclassified
    fill_frame(60, 8'h00);
    send_frame(7'd99);
    fill_frame(60, 8'hFF);
    send_frame(7'd0);
    // one each of syn, syn-ack and fin with a plain 20-byte ip and tcp header
    build_tcp(4'd5, 4'd5, F_SYN, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 6);
    send_frame(7'd99);
    build_tcp(4'd5, 4'd5, F_SYNACK, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 6);
    send_frame(7'd0);
    build_tcp(4'd5, 4'd5, F_FIN | F_ACK, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 6);
    send_frame(7'd0);
    // pure ack: draw below and above the percentage
    build_tcp(4'd5, 4'd5, F_ACK, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 6);
    send_frame(7'd0);
    build_tcp(4'd5, 4'd5, F_ACK, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 6);
    send_frame(7'd99);
    // data with a draw beyond 99, which the compare takes as is
    build_tcp(4'd5, 4'd5, F_PSH | F_ACK, 10, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 0);
    send_frame(7'd127);
    // no flags and no payload
    build_tcp(4'd5, 4'd5, 8'h00, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 6);
    send_frame(7'd0);
    // one byte short of the minimum length
    build_tcp(4'd5, 4'd5, F_SYN, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, -1);
    send_frame(7'd0);
    // not ipv4, not tcp
    build_tcp(4'd5, 4'd5, F_SYN, 0, 16'h86DD, IP_PROTO_TCP, 0, 6);
    send_frame(7'd0);
    build_tcp(4'd5, 4'd5, F_SYN, 0, ETHERTYPE_IPV4, 8'd17, 0, 6);
    send_frame(7'd0);
    // short ihl: tcp header lands inside what would be the ip header
    build_tcp(4'd2, 4'd5, F_SYN, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 12);
    send_frame(7'd0);
    // largest ihl with the frame too short to hold it
    build_tcp(4'd15, 4'd5, F_SYN, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, -30);
    send_frame(7'd0);
    // ip total length below the two headers
    build_tcp(4'd5, 4'd5, F_ACK, 0, ETHERTYPE_IPV4, IP_PROTO_TCP, -4, 6);
    send_frame(7'd0);
    // largest tcp data offset with a little payload
    build_tcp(4'd5, 4'd15, F_ACK, 4, ETHERTYPE_IPV4, IP_PROTO_TCP, 0, 0);
    send_frame(7'd50);
  endtask

  initial begin
    frame_ch.valid          = 1'b0;
    frame_ch.frame_byte     = '0;
    frame_ch.frame_end      = 1'b0;
    frame_ch.random_percent = '0;
    verdict_ch.ready        = 1'b0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sender mostly busy, receiver mostly stalled; small drop-first counts so
    // both the dropped and the passed side of each limit are seen
    src_idle_pct = 21;
    snk_idle_pct = 80;
    program_regs(16'd2, 16'd1, 16'd3, 7'd50, 16'd3, 7'd20);
    directed_frames();
    random_traffic(280, 4);
    wait_idle();

    // the other way round, registers at their maxima but the data percentage at 100
    src_idle_pct = 80;
    snk_idle_pct = 21;
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127, 16'hFFFF, 7'd100);
    random_traffic(280, 4);
    wait_idle();

    // no idling: every rule off, then random mid-range settings
    src_idle_pct = 0;
    snk_idle_pct = 0;
    program_regs(16'd0, 16'd0, 16'd0, 7'd0, 16'd0, 7'd0);
    random_traffic(160, 3);
    wait_idle();
    program_regs(16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)),
                 16'($urandom_range(1, 30)), 7'($urandom_range(1, 99)),
                 16'($urandom_range(1, 80)), 7'($urandom_range(1, 99)));
    random_traffic(160, 3);
    wait_idle();

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
